FILE: design/dedup_slot_work_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DEDUP_SLOT_WORK_SCHEDULER_DEFINES_SVH
`define DEDUP_SLOT_WORK_SCHEDULER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DSWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define DSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/dsws_pkg.sv
// Package for the deduplicating slot work scheduler.
// Holds shared constants, codes and the controller/datapath command types.
package dsws_pkg;

    localparam int DEF_SLOTS = 8;
    localparam int MAX_RESULTS = 8;
    localparam logic [15:0] DEF_TIMEOUT = 16'd3000;

    localparam logic [2:0] OP_ENQ = 3'd0;
    localparam logic [2:0] OP_DISP = 3'd1;
    localparam logic [2:0] OP_FIN = 3'd2;
    localparam logic [2:0] OP_DRAIN = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_COMPLETE = 2'd3;

    localparam logic [3:0] RS_QUEUED = 4'd0;
    localparam logic [3:0] RS_DUP = 4'd1;
    localparam logic [3:0] RS_BUSY = 4'd2;
    localparam logic [3:0] RS_INVALID = 4'd3;
    localparam logic [3:0] RS_DISPATCHED = 4'd4;
    localparam logic [3:0] RS_EXPIRED = 4'd5;
    localparam logic [3:0] RS_NONE = 4'd6;
    localparam logic [3:0] RS_COMPLETION = 4'd7;
    localparam logic [3:0] RS_NO_COMP = 4'd8;
    localparam logic [3:0] RS_FINISHED = 4'd9;
    localparam logic [3:0] RS_IGNORED = 4'd10;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  slot_index;
        logic [15:0] work_out;
        logic [7:0]  status_out;
        logic        timed_out;
        logic [15:0] remaining_ms;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] work_id;
        logic [2:0]  slot_sel;
        logic [7:0]  run_status;
        logic [31:0] now_ms;
    } item_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic scan_start; // restart the scan counter
        logic scan_step;  // evaluate the current scan slot
        logic enq_dup;    // duplicate scan of the enqueue id
        logic enq_free;   // lowest-empty scan of the enqueue id
        logic disp;       // round-robin dispatch scan
        logic drain;      // completed-slot scan
        logic requeue;    // pick next requeue id
        logic fin;        // finish
        logic clear;      // clear all slots
    } cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic       hit;       // scan step found its slot, result pending
        logic       scan_done; // scan counter at its final slot
        logic       rq_avail;  // requeue id waiting
        logic       rq_more;   // another requeue id after the current one
        logic       any_drained;
        logic       drain_last; // this drain hit is the last result of the drain
    } stat_t;

endpackage

FILE: design/dsws_if.sv
// Valid/ready channel interface for the slot scheduler.
// Generic payload type; no package dependency.
interface dsws_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/dsws_datapath.sv
// Slot table and scan datapath of the slot scheduler.
// Uses dsws_pkg; driven by dsws_ctrl through cmd_t and stat_t.
module dsws_datapath #(
    parameter int SLOTS = dsws_pkg::DEF_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dsws_pkg::cmd_t      cmd,
    input  dsws_pkg::item_t     item,
    input  logic [15:0]         timeout_ms,
    output dsws_pkg::stat_t     stat,
    output dsws_pkg::result_t   res
);
    import dsws_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = $clog2(MAX_RESULTS + 1);

    logic [1:0]  st_reg [SLOTS];
    logic [1:0]  st_next [SLOTS];
    logic [15:0] work_reg [SLOTS];
    logic [31:0] time_reg [SLOTS];
    logic [7:0]  rstat_reg [SLOTS];
    logic        exp_reg [SLOTS];
    logic        again_reg [SLOTS];
    logic        again_next [SLOTS];
    logic [IW-1:0] pick_reg, pick_next;
    item_t       item_reg;
    logic [IW-1:0] scan_reg, scan_next;
    logic [IW-1:0] cur;
    logic [IW:0] rr_sum;
    logic        scan_last;
    logic        more_done;
    logic [15:0] rq_id_reg [MAX_RESULTS];
    logic [RW-1:0] rq_n_reg, rq_n_next, rq_k_reg, rq_k_next;
    logic [RW-1:0] nres_reg, nres_next;
    logic [15:0] cur_id;
    logic        hit;
    result_t     pend;
    logic [31:0] age;
    logic        wr_q, wr_done;
    logic [15:0] rs_work;
    logic        sel_ok;

    assign rr_sum = (IW+1)'(pick_reg) + (IW+1)'(scan_reg) + (IW+1)'(1);
    assign cur = !cmd.disp ? scan_reg
               : (rr_sum >= (IW+1)'(SLOTS)) ? IW'(rr_sum - (IW+1)'(SLOTS)) : IW'(rr_sum);
    assign scan_last = (scan_reg == IW'(SLOTS - 1));
    assign cur_id = cmd.requeue ? rq_id_reg[rq_k_reg[$clog2(MAX_RESULTS)-1:0]]
                                : item_reg.work_id;
    assign age = item_reg.now_ms - time_reg[cur];
    assign sel_ok = (32'(item_reg.slot_sel) < 32'(SLOTS));

    always_comb
    begin
        more_done = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (32'(j) > 32'(cur) && st_reg[j] == ST_COMPLETE)
                more_done = 1'b1;
        end
    end

    always_comb
    begin
        hit = 1'b0;
        wr_q = 1'b0;
        wr_done = 1'b0;
        pend = '0;
        rs_work = work_reg[cur];
        if (cmd.scan_step && cmd.enq_dup)
        begin
            if (st_reg[cur] != ST_EMPTY && work_reg[cur] == cur_id)
            begin
                hit = 1'b1;
                pend.status = RS_DUP;
                pend.slot_index = 3'(cur);
                pend.work_out = cur_id;
            end
        end
        else if (cmd.scan_step && cmd.enq_free)
        begin
            if (st_reg[cur] == ST_EMPTY)
            begin
                hit = 1'b1;
                wr_q = 1'b1;
                pend.status = RS_QUEUED;
                pend.slot_index = 3'(cur);
                pend.work_out = cur_id;
            end
        end
        else if (cmd.scan_step && cmd.disp)
        begin
            if (st_reg[cur] == ST_QUEUED)
            begin
                hit = 1'b1;
                pend.slot_index = 3'(cur);
                pend.work_out = rs_work;
                if (age >= {16'd0, timeout_ms})
                begin
                    pend.status = RS_EXPIRED;
                    pend.timed_out = 1'b1;
                end
                else
                begin
                    pend.status = RS_DISPATCHED;
                    pend.remaining_ms = timeout_ms - age[15:0];
                end
            end
        end
        else if (cmd.scan_step && cmd.drain)
        begin
            if (st_reg[cur] == ST_COMPLETE)
            begin
                hit = 1'b1;
                wr_done = 1'b1;
                pend.status = RS_COMPLETION;
                pend.slot_index = 3'(cur);
                pend.work_out = rs_work;
                pend.status_out = rstat_reg[cur];
                pend.timed_out = exp_reg[cur];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            st_next[i] = st_reg[i];
            again_next[i] = again_reg[i];
        end
        pick_next = pick_reg;
        scan_next = scan_reg;
        rq_n_next = rq_n_reg;
        rq_k_next = rq_k_reg;
        nres_next = nres_reg;
        if (cmd.load)
        begin
            rq_n_next = '0;
            rq_k_next = '0;
            nres_next = '0;
        end
        if (cmd.scan_start)
            scan_next = '0;
        else if (cmd.scan_step)
            scan_next = IW'(scan_reg + IW'(1));
        if (hit && cmd.enq_dup && st_reg[cur] != ST_QUEUED && !cmd.requeue)
            again_next[cur] = 1'b1;
        if (wr_q)
        begin
            st_next[cur] = ST_QUEUED;
            again_next[cur] = 1'b0;
        end
        if (hit && cmd.disp)
        begin
            pick_next = cur;
            st_next[cur] = pend.timed_out ? ST_COMPLETE : ST_RUNNING;
        end
        if (wr_done)
        begin
            st_next[cur] = ST_EMPTY;
            again_next[cur] = 1'b0;
            nres_next = RW'(nres_reg + RW'(1));
            if (again_reg[cur])
                rq_n_next = RW'(rq_n_reg + RW'(1));
        end
        if (cmd.requeue && (hit || (cmd.enq_free && scan_last)))
            rq_k_next = RW'(rq_k_reg + RW'(1));
        if (cmd.fin && sel_ok && st_reg[item_reg.slot_sel[IW-1:0]] == ST_RUNNING)
            st_next[item_reg.slot_sel[IW-1:0]] = ST_COMPLETE;
        if (cmd.clear)
            for (int i = 0; i < SLOTS; i++)
            begin
                st_next[i] = ST_EMPTY;
                again_next[i] = 1'b0;
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i] <= ST_EMPTY;
                again_reg[i] <= 1'b0;
            end
            pick_reg <= '0;
            scan_reg <= '0;
            rq_n_reg <= '0;
            rq_k_reg <= '0;
            nres_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i] <= st_next[i];
                again_reg[i] <= again_next[i];
            end
            pick_reg <= pick_next;
            scan_reg <= scan_next;
            rq_n_reg <= rq_n_next;
            rq_k_reg <= rq_k_next;
            nres_reg <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (wr_q)
        begin
            work_reg[cur] <= cur_id;
            time_reg[cur] <= item_reg.now_ms;
        end
        if (hit && cmd.disp && pend.timed_out)
        begin
            rstat_reg[cur] <= 8'd0;
            exp_reg[cur] <= 1'b1;
        end
        if (wr_done && again_reg[cur])
            rq_id_reg[rq_n_reg[$clog2(MAX_RESULTS)-1:0]] <= rs_work;
        if (cmd.fin && sel_ok && st_reg[item_reg.slot_sel[IW-1:0]] == ST_RUNNING)
        begin
            rstat_reg[item_reg.slot_sel[IW-1:0]] <= item_reg.run_status;
            exp_reg[item_reg.slot_sel[IW-1:0]] <= 1'b0;
        end
    end

    // Finish and fixed results are built here from the captured item.
    always_comb
    begin
        res = pend;
        if (cmd.fin)
        begin
            res = '0;
            res.slot_index = item_reg.slot_sel;
            if (sel_ok && st_reg[item_reg.slot_sel[IW-1:0]] == ST_RUNNING)
            begin
                res.status = RS_FINISHED;
                res.work_out = work_reg[item_reg.slot_sel[IW-1:0]];
                res.status_out = item_reg.run_status;
            end
            else
                res.status = RS_IGNORED;
        end
        else if (cmd.enq_free && scan_last && !hit)
        begin
            res = '0;
            res.status = RS_BUSY;
        end
        else if (cmd.load)
        begin
            res = '0;
            res.status = RS_INVALID;
        end
        else if (cmd.disp && scan_last && !hit)
        begin
            res = '0;
            res.status = RS_NONE;
        end
        else if (cmd.drain && scan_last && !hit && nres_reg == '0)
        begin
            res = '0;
            res.status = RS_NO_COMP;
        end
    end

    assign stat.hit = hit;
    assign stat.scan_done = scan_last;
    assign stat.rq_avail = (rq_k_reg != rq_n_reg);
    assign stat.rq_more = (RW'(rq_k_reg + RW'(1)) != rq_n_reg);
    assign stat.any_drained = (nres_reg != '0);
    assign stat.drain_last = !more_done || (32'(nres_next) >= 32'(MAX_RESULTS));
endmodule

FILE: design/dsws_ctrl.sv
// Controller state machine of the slot scheduler.
// Uses dsws_pkg and the defines header; commands dsws_datapath.
`include "dedup_slot_work_scheduler_defines.svh"
module dsws_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_op,
    input  logic [15:0]         in_id,
    input  dsws_pkg::stat_t     stat,
    input  dsws_pkg::result_t   res,
    output dsws_pkg::cmd_t      cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output dsws_pkg::result_t   out_res
);
    import dsws_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DUP    = 9'b000000010,
        S_FREE   = 9'b000000100,
        S_DISP   = 9'b000001000,
        S_FIN    = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_RQDUP  = 9'b001000000,
        S_RQFREE = 9'b010000000,
        S_WAIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   pend_reg, pend_next;
    result_t pres_reg, pres_next;
    logic   ovalid_reg, ovalid_next;
    result_t ores_reg, ores_next;
    logic   emit;
    logic   accept;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ret_next = ret_reg;
        pend_next = pend_reg;
        pres_next = pres_reg;
        emit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_start = 1'b1;
                    priority if (in_op == OP_ENQ && in_id == 16'd0)
                    begin
                        state_next = S_WAIT;
                        ret_next = S_IDLE;
                        pend_next = 1'b1;
                        pres_next = '0;
                        pres_next.status = RS_INVALID;
                        pres_next.last = 1'b1;
                    end
                    else if (in_op == OP_ENQ)
                        state_next = S_DUP;
                    else if (in_op == OP_DISP)
                        state_next = S_DISP;
                    else if (in_op == OP_FIN)
                        state_next = S_FIN;
                    else if (in_op == OP_DRAIN)
                        state_next = S_DRAIN;
                    else if (in_op == OP_CLEAR)
                        cmd.clear = 1'b1;
                end
            end
            S_DUP, S_RQDUP:
            begin
                cmd.scan_step = 1'b1;
                cmd.enq_dup = 1'b1;
                cmd.requeue = (state_reg == S_RQDUP);
                if (stat.hit)
                begin
                    cmd.scan_start = 1'b1;
                    if (state_reg == S_DUP)
                    begin
                        emit = 1'b1;
                        pres_next = res;
                        pres_next.last = 1'b1;
                        ret_next = S_IDLE;
                        state_next = S_WAIT;
                    end
                    else
                        state_next = stat.rq_more ? S_RQDUP : S_IDLE;
                end
                else if (stat.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = (state_reg == S_DUP) ? S_FREE : S_RQFREE;
                end
            end
            S_FREE, S_RQFREE:
            begin
                cmd.scan_step = 1'b1;
                cmd.enq_free = 1'b1;
                cmd.requeue = (state_reg == S_RQFREE);
                if (stat.hit || stat.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    if (state_reg == S_FREE)
                    begin
                        emit = 1'b1;
                        pres_next = res;
                        pres_next.last = 1'b1;
                        ret_next = S_IDLE;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (stat.hit && stat.rq_more)
                            state_next = S_RQDUP;
                    end
                end
            end
            S_DISP:
            begin
                cmd.scan_step = 1'b1;
                cmd.disp = 1'b1;
                if (stat.hit || stat.scan_done)
                begin
                    emit = 1'b1;
                    pres_next = res;
                    pres_next.last = 1'b1;
                    ret_next = S_IDLE;
                    state_next = S_WAIT;
                end
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                emit = 1'b1;
                pres_next = res;
                pres_next.last = 1'b1;
                ret_next = S_IDLE;
                state_next = S_WAIT;
            end
            S_DRAIN:
            begin
                if (pend_reg)
                begin
                    if (!ovalid_reg || out_ready)
                        pend_next = 1'b0;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.drain = 1'b1;
                    if (stat.hit)
                    begin
                        pend_next = 1'b1;
                        pres_next = res;
                        pres_next.last = stat.drain_last;
                    end
                    if ((stat.hit && stat.drain_last) || (!stat.hit && stat.scan_done))
                    begin
                        cmd.scan_start = 1'b1;
                        if (!stat.hit && !stat.any_drained)
                        begin
                            pend_next = 1'b1;
                            pres_next = res;
                            pres_next.last = 1'b1;
                        end
                        state_next = S_WAIT;
                        ret_next = S_RQDUP;
                    end
                end
            end
            S_WAIT:
            begin
                if (!pend_reg)
                begin
                    if (ret_reg == S_RQDUP && !stat.rq_avail)
                        state_next = S_IDLE;
                    else
                        state_next = ret_reg;
                end
                else if (!ovalid_reg || out_ready)
                    pend_next = 1'b0;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (emit)
            pend_next = 1'b1;
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        ores_next = ores_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        if (pend_reg && (!ovalid_reg || out_ready))
        begin
            ovalid_next = 1'b1;
            ores_next = pres_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            pend_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            pend_reg <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pres_reg <= pres_next;
        ores_reg <= ores_next;
    end

    assign out_valid = ovalid_reg;
    assign out_res = ores_reg;

    `DSWS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !pend_reg)
    `DSWS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_res))
    `DSWS_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_res.status <= RS_IGNORED)
endmodule

FILE: design/dedup_slot_work_scheduler.sv
// Top level of the deduplicating round-robin slot scheduler.
// Uses dsws_pkg, dsws_if, dsws_ctrl and dsws_datapath.
//
// One item at a time; the input is ready only while the controller is idle.
// After the accepting edge, enqueue scans for a duplicate one slot per cycle
// (up to SLOTS slots) and then for the lowest empty slot (up to SLOTS more);
// dispatch scans up to SLOTS slots; finish is decided in S_FIN; drain scans one
// slot per cycle up to the last completed slot and waits at each result
// until the output register can take it, then requeues each marked entry
// through the duplicate and empty-slot scans. Every other item that
// yields a result passes it through S_WAIT into the one-entry output
// register before returning to idle, and an output stall holds it there.
module dedup_slot_work_scheduler #(
    parameter int SLOTS = dsws_pkg::DEF_SLOTS
) (
    input  logic     clk,
    input  logic     rst_n,
    dsws_if.sink     in_ch,
    dsws_if.source   out_ch,
    dsws_if.sink     cfg
);
    import dsws_pkg::*;

    logic [15:0] timeout_reg;
    cmd_t    cmd;
    stat_t   stat;
    result_t res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= DEF_TIMEOUT;
        else if (cfg.valid)
            timeout_reg <= cfg.payload;
    end

    dsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_op     (in_ch.payload.operation),
        .in_id     (in_ch.payload.work_id),
        .stat      (stat),
        .res       (res),
        .cmd       (cmd),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_ch.payload)
    );

    dsws_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (in_ch.payload),
        .timeout_ms (timeout_reg),
        .stat       (stat),
        .res        (res)
    );
endmodule

FILE: tb/sv/tb_dsws_if.sv
// Interface instances used by the scheduler testbench are the RTL's dsws_if.
// This file holds the scoreboard class that predicts results; depends on dsws_pkg.
package tb_dsws_sb_pkg;
    import dsws_pkg::*;

    class sched_scoreboard;
        localparam int N = 8;
        logic [1:0]  state_q[N];
        logic [15:0] work_q[N];
        logic [31:0] time_q[N];
        logic [7:0]  rstat_q[N];
        logic        exp_q[N];
        logic        again_q[N];
        int unsigned pick;
        logic [15:0] timeout;
        result_t     pending[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < N; i++)
            begin
                state_q[i] = ST_EMPTY;
                again_q[i] = 1'b0;
                work_q[i] = '0;
                time_q[i] = '0;
                rstat_q[i] = '0;
                exp_q[i] = 1'b0;
            end
            pick = 0;
            timeout = DEF_TIMEOUT;
            errors = 0;
            checked = 0;
        endfunction

        function void push_result(logic [3:0] st, int idx, logic [15:0] w, logic [7:0] rs,
                                  logic to, logic [15:0] rem);
            result_t r;
            r.status = st;
            r.slot_index = idx[2:0];
            r.work_out = w;
            r.status_out = rs;
            r.timed_out = to;
            r.remaining_ms = rem;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function logic [3:0] enqueue(logic [15:0] id, logic [31:0] now, output int idx);
            idx = 0;
            if (id == 0)
                return RS_INVALID;
            for (int i = 0; i < N; i++)
            begin
                if (state_q[i] != ST_EMPTY && work_q[i] == id)
                begin
                    if (state_q[i] != ST_QUEUED)
                        again_q[i] = 1'b1;
                    idx = i;
                    return RS_DUP;
                end
            end
            for (int i = 0; i < N; i++)
            begin
                if (state_q[i] == ST_EMPTY)
                begin
                    state_q[i] = ST_QUEUED;
                    work_q[i] = id;
                    time_q[i] = now;
                    again_q[i] = 1'b0;
                    idx = i;
                    return RS_QUEUED;
                end
            end
            return RS_BUSY;
        endfunction

        function void note_item(item_t it);
            int          n0;
            int          idx;
            int          s;
            int          nd;
            logic [3:0]  st;
            logic [31:0] age;
            logic [15:0] again_ids[$];
            n0 = pending.size();
            case (it.operation)
                OP_ENQ:
                begin
                    st = enqueue(it.work_id, it.now_ms, idx);
                    push_result(st, idx, (st == RS_QUEUED || st == RS_DUP) ? it.work_id : '0,
                                '0, 1'b0, '0);
                end
                OP_DISP:
                begin
                    s = -1;
                    for (int i = 1; i <= N; i++)
                    begin
                        if (s < 0 && state_q[(pick + i) % N] == ST_QUEUED)
                            s = (pick + i) % N;
                    end
                    if (s < 0)
                        push_result(RS_NONE, 0, '0, '0, 1'b0, '0);
                    else
                    begin
                        pick = s;
                        age = it.now_ms - time_q[s];
                        if (age >= {16'd0, timeout})
                        begin
                            state_q[s] = ST_COMPLETE;
                            rstat_q[s] = '0;
                            exp_q[s] = 1'b1;
                            push_result(RS_EXPIRED, s, work_q[s], '0, 1'b1, '0);
                        end
                        else
                        begin
                            state_q[s] = ST_RUNNING;
                            push_result(RS_DISPATCHED, s, work_q[s], '0, 1'b0,
                                        timeout - age[15:0]);
                        end
                    end
                end
                OP_FIN:
                begin
                    s = it.slot_sel;
                    if (state_q[s] == ST_RUNNING)
                    begin
                        state_q[s] = ST_COMPLETE;
                        rstat_q[s] = it.run_status;
                        exp_q[s] = 1'b0;
                        push_result(RS_FINISHED, s, work_q[s], it.run_status, 1'b0, '0);
                    end
                    else
                        push_result(RS_IGNORED, s, '0, '0, 1'b0, '0);
                end
                OP_DRAIN:
                begin
                    nd = 0;
                    for (int i = 0; i < N; i++)
                    begin
                        if (state_q[i] == ST_COMPLETE && nd < MAX_RESULTS)
                        begin
                            push_result(RS_COMPLETION, i, work_q[i], rstat_q[i], exp_q[i], '0);
                            nd++;
                            if (again_q[i])
                                again_ids.push_back(work_q[i]);
                            state_q[i] = ST_EMPTY;
                            again_q[i] = 1'b0;
                        end
                    end
                    foreach (again_ids[k])
                        void'(enqueue(again_ids[k], it.now_ms, idx));
                    if (nd == 0)
                        push_result(RS_NO_COMP, 0, '0, '0, 1'b0, '0);
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        state_q[i] = ST_EMPTY;
                        again_q[i] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (pending.size() > n0)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.slot_index !== e.slot_index)
            begin
                $error("slot_index expected %0d actual %0d", e.slot_index, got.slot_index);
                errors++;
            end
            if (got.work_out !== e.work_out)
            begin
                $error("work_out expected %0h actual %0h", e.work_out, got.work_out);
                errors++;
            end
            if (got.status_out !== e.status_out)
            begin
                $error("status_out expected %0h actual %0h", e.status_out, got.status_out);
                errors++;
            end
            if (got.timed_out !== e.timed_out)
            begin
                $error("timed_out expected %0b actual %0b", e.timed_out, got.timed_out);
                errors++;
            end
            if (got.remaining_ms !== e.remaining_ms)
            begin
                $error("remaining_ms expected %0d actual %0d", e.remaining_ms, got.remaining_ms);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last expected %0b actual %0b", e.last, got.last);
                errors++;
            end
        endfunction
    endclass
endpackage

FILE: tb/sv/tb.sv
// Testbench top for dedup_slot_work_scheduler: directed and random commands,
// random stalls on both channels, and result checking. Depends on dsws_pkg, dsws_if.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsws_pkg::*;
    import tb_dsws_sb_pkg::*;

    logic clk;
    logic rst_n;
    dsws_if #(.payload_t(item_t)) in_ch ();
    dsws_if #(.payload_t(result_t)) out_ch ();
    dsws_if #(.payload_t(logic [15:0])) cfg ();

    dedup_slot_work_scheduler i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    sched_scoreboard sb;
    int   idle_cycles;
    int   items_sent;
    bit   hold_off;
    bit   stim_done;
    logic [15:0] id_pool[6] = '{16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h1234, 16'h0002};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_item(in_ch.payload);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.payload);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op, logic [15:0] id, logic [2:0] sel,
                             logic [7:0] rs, logic [31:0] now);
        item_t it;
        int gap;
        it.operation = op;
        it.work_id = id;
        it.slot_sel = sel;
        it.run_status = rs;
        it.now_ms = now;
        gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 18)) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        cfg.valid <= 1'b1;
        cfg.payload <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        sb.timeout = v;
    endtask

    task automatic random_phase(int count, logic [31:0] base);
        logic [31:0] now;
        int r;
        now = base;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            now = now + $urandom_range(0, 1500);
            if (r < 35)
                send_item(OP_ENQ, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                          id_pool[$urandom_range(0, 5)], 3'($urandom), 8'($urandom), now);
            else if (r < 60)
                send_item(OP_DISP, 16'($urandom), 3'($urandom), 8'($urandom), now);
            else if (r < 80)
                send_item(OP_FIN, 16'($urandom), 3'($urandom), 8'($urandom), now);
            else if (r < 95)
                send_item(OP_DRAIN, 16'($urandom), 3'($urandom), 8'($urandom), now);
            else if (r < 97)
                send_item(OP_CLEAR, 16'($urandom), 3'($urandom), 8'($urandom), now);
            else
                send_item(3'($urandom_range(5, 7)), 16'($urandom), 3'($urandom),
                          8'($urandom), now);
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (out_ch.ready && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        sb = new();
        idle_cycles = 0;
        items_sent = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg.valid = 1'b0;
        cfg.payload = '0;
        @(posedge rst_n);
        @(posedge clk);

        send_item(OP_DISP, 16'd0, 3'd0, 8'd0, 32'd0);
        send_item(OP_DRAIN, 16'd0, 3'd0, 8'd0, 32'd0);
        send_item(OP_ENQ, 16'h0000, 3'd0, 8'd0, 32'd0);
        for (int i = 0; i < 8; i++)
            send_item(OP_ENQ, 16'(16'hFFF0 + i), 3'd0, 8'd0, 32'd100);
        send_item(OP_ENQ, 16'h0001, 3'd0, 8'd0, 32'd100);
        send_item(OP_ENQ, 16'hFFF3, 3'd0, 8'd0, 32'd100);
        send_item(OP_DISP, 16'd0, 3'd0, 8'd0, 32'd200);
        send_item(OP_DISP, 16'd0, 3'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(OP_FIN, 16'd0, 3'd1, 8'hFF, 32'd0);
        send_item(OP_FIN, 16'd0, 3'd1, 8'h00, 32'd0);
        send_item(OP_FIN, 16'd0, 3'd7, 8'h55, 32'd0);
        send_item(OP_ENQ, 16'hFFF1, 3'd0, 8'd0, 32'd0);
        send_item(OP_DRAIN, 16'd0, 3'd0, 8'd0, 32'd300);
        send_item(OP_CLEAR, 16'd0, 3'd0, 8'd0, 32'd0);
        send_item(3'd7, 16'hFFFF, 3'd7, 8'hFF, 32'hFFFF_FFFF);
        wait_quiet();

        // Let the output side stall while commands pile up behind it.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(15, 32'd0);
        join
        wait_quiet();

        write_timeout(16'd0);
        random_phase(25, 32'hFFFF_F000);
        wait_quiet();
        write_timeout(16'hFFFF);
        random_phase(30, 32'd0);
        wait_quiet();
        write_timeout(16'd2000);
        random_phase(30, 32'h1234_0000);
        wait_quiet();

        $display("Sent %0d commands over four timeout settings; %0d results checked.",
                 items_sent, sb.checked);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
